// File: sv/bitmap_entry_allocator_assert.svh
// Assertion macros for the bitmap entry allocator.
// Relies on clk and rst being visible in the including module.
`ifndef BITMAP_ENTRY_ALLOCATOR_ASSERT_SVH
`define BITMAP_ENTRY_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BEA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define BEA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/bea_pkg.sv
// Shared constants for the bitmap entry allocator.
// No dependencies; used by bitmap_entry_allocator, allocator_checker and the testbench top.
`default_nettype none

package bea_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int WORD_W      = 32;                      // map bits per RAM row
  localparam int BIT_W       = $clog2(WORD_W);
  localparam int ROWS        = MAX_ENTRIES / WORD_W;
  localparam int ROW_W       = $clog2(ROWS);
  localparam int IDX_W       = 10;
  localparam int CNT_W       = 11;
  localparam int POP_W       = BIT_W + 1;

  localparam logic [CNT_W-1:0] CNT_MAX     = '1;
  localparam logic [CNT_W-1:0] ENTRIES_MAX = CNT_W'(MAX_ENTRIES);

  localparam logic [2:0] OP_INIT  = 3'd0;
  localparam logic [2:0] OP_ALLOC = 3'd1;
  localparam logic [2:0] OP_FREE  = 3'd2;
  localparam logic [2:0] OP_QUERY = 3'd3;
  localparam logic [2:0] OP_COUNT = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NONE  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic REG_ENTRY_COUNT = 1'b0;
  localparam logic REG_ROOT_INDEX  = 1'b1;

endpackage

`default_nettype wire

// File: sv/bea_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module bea_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: sv/bitmap_entry_allocator.sv
// First-fit allocator over a used/free bitmap held in a 32 x 32-bit RAM.
// Depends on bea_pkg, bea_ram and bitmap_entry_allocator_assert.svh.
//
// A command is taken when start is high and busy is low. Its result shows for
// exactly one cycle with done high and cannot be held off by the receiver;
// busy is low again in that same cycle, so the next command may go in at once.
// Unknown operations and commands rejected on range finish straight from idle;
// init writes row 0 and, when the root lies outside row 0, the root row too;
// free and query pass through a read and then a modify state; allocate and
// count scan up to R = ceil(active entries / 32) rows, 32 with 1024 entries.
// Allocate and count are paced by the map RAM read port, one 32-bit row per
// cycle. After reset the map reads all free with no clearing pass: a per-row
// valid bit masks rows never written.
`default_nettype none

module bitmap_entry_allocator (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [2:0]                  operation,
  input  wire logic [bea_pkg::IDX_W-1:0]   entry_index,
  output logic                             done,
  output logic      [1:0]                  status,
  output logic      [bea_pkg::IDX_W-1:0]   result_index,
  output logic                             is_used,
  output logic      [bea_pkg::CNT_W-1:0]   free_total,
  input  wire logic                        wr_en,
  input  wire logic                        wr_index,
  input  wire logic [bea_pkg::CNT_W-1:0]   wr_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INIT0 = 3'd1;
  localparam logic [2:0] S_INIT1 = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_MOD   = 3'd5;

  localparam int WORD_W = bea_pkg::WORD_W;
  localparam int BIT_W  = bea_pkg::BIT_W;
  localparam int ROWS   = bea_pkg::ROWS;
  localparam int ROW_W  = bea_pkg::ROW_W;
  localparam int IDX_W  = bea_pkg::IDX_W;
  localparam int CNT_W  = bea_pkg::CNT_W;
  localparam int POP_W  = bea_pkg::POP_W;

  logic [2:0]       state;
  logic [2:0]       op_q;
  logic [IDX_W-1:0] idx_q;
  logic [CNT_W-1:0] n_q;
  logic [ROW_W-1:0] last_row;
  logic [ROW_W:0]   rd_row;
  logic             chk_pending;
  logic [ROW_W-1:0] chk_row;
  logic [CNT_W-1:0] total;
  logic [CNT_W-1:0] free_counter;
  logic [CNT_W-1:0] entry_count;
  logic [IDX_W-1:0] root_index;
  logic [ROWS-1:0]  row_valid;

  logic              ram_we;
  logic [ROW_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [ROW_W-1:0]  ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  logic [CNT_W-1:0]  n_eff;
  logic [CNT_W-1:0]  n_eff_m1;
  logic [CNT_W-1:0]  n_q_m1;
  logic [CNT_W-1:0]  init_cnt;
  logic [CNT_W-1:0]  cnt_dec;
  logic [CNT_W-1:0]  cnt_inc;
  logic [ROW_W-1:0]  mod_row;
  logic [BIT_W-1:0]  mod_bit;
  logic [ROW_W-1:0]  root_row;
  logic [BIT_W-1:0]  root_bit;
  logic [WORD_W-1:0] word_mod;
  logic [WORD_W-1:0] word_chk;
  logic [WORD_W-1:0] scan_mask;
  logic [WORD_W-1:0] avail;
  logic              hit;
  logic [BIT_W-1:0]  hit_bit;
  logic [POP_W-1:0]  pop;
  logic [CNT_W-1:0]  total_sum;
  logic              chk_last;

  bea_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ROWS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy = (state != S_IDLE);

  assign n_eff    = (entry_count > bea_pkg::ENTRIES_MAX) ? bea_pkg::ENTRIES_MAX : entry_count;
  assign n_eff_m1 = n_eff - CNT_W'(1);
  assign n_q_m1   = n_q - CNT_W'(1);
  assign init_cnt = (n_q >= CNT_W'(2)) ? (n_q - CNT_W'(2)) : '0;
  assign cnt_dec  = (free_counter == '0) ? '0 : (free_counter - CNT_W'(1));
  assign cnt_inc  = (free_counter == bea_pkg::CNT_MAX) ? free_counter
                                                       : (free_counter + CNT_W'(1));

  assign mod_row  = idx_q[IDX_W-1:BIT_W];
  assign mod_bit  = idx_q[BIT_W-1:0];
  assign root_row = root_index[IDX_W-1:BIT_W];
  assign root_bit = root_index[BIT_W-1:0];

  // rows never written since reset or init read as all free
  assign word_mod = row_valid[mod_row] ? ram_rdata : '0;
  assign word_chk = row_valid[chk_row] ? ram_rdata : '0;
  assign chk_last = (chk_row == last_row);

  always_comb begin
    for (int k = 0; k < WORD_W; k++) begin
      scan_mask[k] = (!chk_last || (BIT_W'(k) <= n_q_m1[BIT_W-1:0])) &&
                     !((chk_row == '0) && (k == 0));
    end
  end

  assign avail = ~word_chk & scan_mask;
  assign hit   = |avail;

  always_comb begin
    hit_bit = '0;
    for (int k = WORD_W - 1; k >= 0; k--) begin
      if (avail[k]) begin
        hit_bit = BIT_W'(k);
      end
    end
  end

  always_comb begin
    pop = '0;
    for (int k = 0; k < WORD_W; k++) begin
      pop = pop + POP_W'(avail[k]);
    end
  end

  assign total_sum = total + CNT_W'(pop);

  assign ram_raddr = (state == S_SCAN) ? rd_row[ROW_W-1:0] : mod_row;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    unique case (state)
      S_INIT0: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = WORD_W'(1) |
                    ((root_row == '0) ? (WORD_W'(1) << root_bit) : '0);
      end
      S_INIT1: begin
        ram_we    = 1'b1;
        ram_waddr = root_row;
        ram_wdata = WORD_W'(1) << root_bit;
      end
      S_SCAN: begin
        ram_we    = chk_pending && (op_q == bea_pkg::OP_ALLOC) && hit;
        ram_waddr = chk_row;
        ram_wdata = word_chk | (WORD_W'(1) << hit_bit);
      end
      S_MOD: begin
        ram_we    = (op_q == bea_pkg::OP_FREE);
        ram_waddr = mod_row;
        ram_wdata = word_mod & ~(WORD_W'(1) << mod_bit);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      done         <= 1'b0;
      chk_pending  <= 1'b0;
      row_valid    <= '0;
      free_counter <= '0;
      entry_count  <= bea_pkg::ENTRIES_MAX;
      root_index   <= IDX_W'(1);
    end else begin
      done <= 1'b0;

      if (wr_en) begin
        unique case (wr_index)
          bea_pkg::REG_ENTRY_COUNT: entry_count <= wr_data;
          bea_pkg::REG_ROOT_INDEX:  root_index  <= wr_data[IDX_W-1:0];
          default:                  entry_count <= entry_count;
        endcase
      end

      if (ram_we) begin
        row_valid[ram_waddr] <= 1'b1;
      end

      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_q         <= operation;
            idx_q        <= entry_index;
            n_q          <= n_eff;
            last_row     <= n_eff_m1[IDX_W-1:BIT_W];
            rd_row       <= '0;
            chk_pending  <= 1'b0;
            total        <= '0;
            status       <= bea_pkg::ST_OK;
            result_index <= '0;
            is_used      <= 1'b0;
            free_total   <= free_counter;
            case (operation) inside
              bea_pkg::OP_INIT: begin
                state <= S_INIT0;
              end
              bea_pkg::OP_ALLOC, bea_pkg::OP_COUNT: begin
                if (n_eff < CNT_W'(2)) begin
                  done <= 1'b1;
                  if (operation == bea_pkg::OP_ALLOC) begin
                    status <= bea_pkg::ST_NONE;
                  end else begin
                    free_total <= '0;
                  end
                end else begin
                  state <= S_SCAN;
                end
              end
              bea_pkg::OP_FREE: begin
                if (entry_index == '0 || CNT_W'(entry_index) >= n_eff) begin
                  status <= bea_pkg::ST_RANGE;
                  done   <= 1'b1;
                end else begin
                  state <= S_READ;
                end
              end
              bea_pkg::OP_QUERY: begin
                if (CNT_W'(entry_index) >= n_eff) begin
                  is_used <= 1'b1;
                  done    <= 1'b1;
                end else begin
                  state <= S_READ;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end

        S_INIT0: begin
          free_counter <= init_cnt;
          free_total   <= init_cnt;
          row_valid    <= ROWS'(1);
          if (root_row == '0) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end else begin
            state <= S_INIT1;
          end
        end

        S_INIT1: begin
          state <= S_IDLE;
          done  <= 1'b1;
        end

        S_SCAN: begin
          // one row issued per cycle; its data is checked in the next cycle
          if (rd_row <= {1'b0, last_row}) begin
            rd_row      <= rd_row + (ROW_W + 1)'(1);
            chk_pending <= 1'b1;
            chk_row     <= rd_row[ROW_W-1:0];
          end else begin
            chk_pending <= 1'b0;
          end
          if (chk_pending) begin
            if (op_q == bea_pkg::OP_ALLOC) begin
              if (hit) begin
                free_counter <= cnt_dec;
                free_total   <= cnt_dec;
                result_index <= {chk_row, hit_bit};
                state        <= S_IDLE;
                done         <= 1'b1;
                chk_pending  <= 1'b0;
              end else if (chk_last) begin
                status      <= bea_pkg::ST_NONE;
                state       <= S_IDLE;
                done        <= 1'b1;
                chk_pending <= 1'b0;
              end
            end else begin
              total <= total_sum;
              if (chk_last) begin
                free_total  <= total_sum;
                state       <= S_IDLE;
                done        <= 1'b1;
                chk_pending <= 1'b0;
              end
            end
          end
        end

        S_READ: begin
          state <= S_MOD;
        end

        S_MOD: begin
          if (op_q == bea_pkg::OP_FREE) begin
            free_counter <= cnt_inc;
            free_total   <= cnt_inc;
          end else begin
            is_used <= word_mod[mod_bit];
          end
          state <= S_IDLE;
          done  <= 1'b1;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`include "bitmap_entry_allocator_assert.svh"

  `BEA_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done, "accepted command stalled")
  `BEA_ASSERT_NOW(a_write_when_busy, ram_we, busy, "map written while idle")
  `BEA_ASSERT_NOW(a_none_only_alloc, done && status == bea_pkg::ST_NONE,
                  result_index == '0 && op_q == bea_pkg::OP_ALLOC, "bad no-free result")
  `BEA_ASSERT_NOW(a_used_only_query, done && is_used, op_q == bea_pkg::OP_QUERY,
                  "is_used set outside query")
  `BEA_ASSERT_NEXT(a_read_then_modify, state == S_READ, state == S_MOD, "read not followed by modify")

endmodule

`default_nettype wire

// File: dv/allocator_checker.sv
`timescale 1ns / 100ps
// Checker for bitmap_entry_allocator: watches commands, register writes and results,
// keeps its own map, counter and register copies, and compares every result.
// Depends on bea_pkg.

module allocator_checker
  import bea_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  logic [2:0]       operation,
  input  logic [IDX_W-1:0] entry_index,
  input  logic             done,
  input  logic [1:0]       status,
  input  logic [IDX_W-1:0] result_index,
  input  logic             is_used,
  input  logic [CNT_W-1:0] free_total,
  input  logic             wr_en,
  input  logic             wr_index,
  input  logic [CNT_W-1:0] wr_data,
  output int               mismatches,
  output int               backlog,
  output int               results_seen,
  output int               grants,
  output int               exhausted
);

  localparam int PRINT_CAP = 50;

  typedef struct packed {
    logic [2:0]       op;
    logic [1:0]       status;
    logic [IDX_W-1:0] grant;
    logic             used;
    logic [CNT_W-1:0] total;
  } alloc_outcome_t;

  logic [MAX_ENTRIES-1:0] map_used;
  logic [CNT_W-1:0]       free_count;
  logic [CNT_W-1:0]       cfg_count;
  logic [IDX_W-1:0]       cfg_root;
  alloc_outcome_t         outcome_q[$];

  initial begin
    mismatches   = 0;
    backlog      = 0;
    results_seen = 0;
    grants       = 0;
    exhausted    = 0;
  end

  // Updates map and counter for one command and returns the result it must produce.
  function automatic alloc_outcome_t apply_command(input logic [2:0] op,
                                                   input logic [IDX_W-1:0] idx);
    alloc_outcome_t r;
    int unsigned    span;
    int unsigned    walked;
    bit             found;
    r      = '0;
    r.op   = op;
    span   = (cfg_count > MAX_ENTRIES) ? MAX_ENTRIES : cfg_count;
    walked = 0;
    found  = 1'b0;
    case (op)
      OP_INIT: begin
        map_used           = '0;
        map_used[0]        = 1'b1;
        map_used[cfg_root] = 1'b1;  // marked even when beyond the active entries
        free_count         = (span >= 2) ? CNT_W'(span - 2) : '0;
      end
      OP_ALLOC: begin
        r.status = ST_NONE;
        for (int i = 1; i < span && !found; i++) begin
          if (!map_used[i]) begin
            found       = 1'b1;
            map_used[i] = 1'b1;
            if (free_count != '0) free_count--;
            r.grant  = IDX_W'(i);
            r.status = ST_OK;
          end
        end
      end
      OP_FREE: begin
        if (idx == '0 || idx >= span) begin
          r.status = ST_RANGE;
        end else begin
          // already-free entries still raise the counter
          map_used[idx] = 1'b0;
          if (free_count != CNT_MAX) free_count++;
        end
      end
      OP_QUERY: begin
        r.used = (idx >= span) ? 1'b1 : map_used[idx];
      end
      OP_COUNT: begin
        for (int i = 1; i < span; i++) begin
          if (!map_used[i]) walked++;
        end
      end
      default: begin
      end
    endcase
    r.total = (op == OP_COUNT) ? CNT_W'(walked) : free_count;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned exp_v,
                                 input int unsigned got_v);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("%0t ns: mismatch on %s: expected %0d, got %0d", $time, what, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin : watch
    alloc_outcome_t want;
    if (rst) begin
      map_used   = '0;
      free_count = '0;
      cfg_count  = ENTRIES_MAX;
      cfg_root   = IDX_W'(1);
      outcome_q.delete();
    end else begin
      if (done === 1'b1) begin
        results_seen++;
        if (outcome_q.size() == 0) begin
          report_mismatch("result transaction with no command outstanding", 0, 1);
        end else begin
          want = outcome_q.pop_front();
          if (status !== want.status)
            report_mismatch($sformatf("op %0d status", want.op), want.status, status);
          if (result_index !== want.grant)
            report_mismatch($sformatf("op %0d result_index", want.op), want.grant,
                            result_index);
          if (is_used !== want.used)
            report_mismatch($sformatf("op %0d is_used", want.op), want.used, is_used);
          if (free_total !== want.total)
            report_mismatch($sformatf("op %0d free_total", want.op), want.total,
                            free_total);
          if (want.op == OP_ALLOC) begin
            if (want.status == ST_OK) grants++;
            else exhausted++;
          end
        end
      end
      if (wr_en === 1'b1) begin
        if (wr_index == REG_ENTRY_COUNT) cfg_count = wr_data;
        else cfg_root = wr_data[IDX_W-1:0];
      end
      if (start === 1'b1 && busy === 1'b0) begin
        outcome_q.push_back(apply_command(operation, entry_index));
      end
    end
    backlog = outcome_q.size();
  end

endmodule

// File: dv/tb_bitmap_entry_allocator.sv
`timescale 1ns / 100ps
// Testbench top for bitmap_entry_allocator: clock, reset, register writes and commands.
// Depends on bea_pkg, bitmap_entry_allocator and allocator_checker.

module tb_bitmap_entry_allocator;
  import bea_pkg::*;

  localparam logic [2:0] OP_SPARE_LO   = 3'd5;
  localparam logic [2:0] OP_SPARE_HI   = 3'd7;
  localparam int         WATCHDOG_LIMIT = 1000;
  localparam int         DRAIN_CYCLES   = 40;
  localparam int         RANDOM_PHASES  = 10;
  localparam int         PHASE_ITEMS    = 60;
  localparam int         SWEEP_FREES    = 200;

  logic             clk;
  logic             rst         = 1'b1;
  logic             start       = 1'b0;
  logic [2:0]       operation   = OP_INIT;
  logic [IDX_W-1:0] entry_index = '0;
  logic             wr_en       = 1'b0;
  logic             wr_index    = REG_ENTRY_COUNT;
  logic [CNT_W-1:0] wr_data     = '0;

  wire              busy;
  wire              done;
  wire [1:0]        status;
  wire [IDX_W-1:0]  result_index;
  wire              is_used;
  wire [CNT_W-1:0]  free_total;

  int               mismatches;
  int               backlog;
  int               results_seen;
  int               grants;
  int               exhausted;

  int unsigned      cur_span        = MAX_ENTRIES;
  int unsigned      burst_left      = 0;
  bit               idling          = 1'b0;
  int unsigned      commands_issued = 0;
  int unsigned      settings_used   = 0;
  int unsigned      stall_cycles    = 0;

  // entry_count / root_index per random phase; the second to last one is drawn at random
  int unsigned plan_count [RANDOM_PHASES] = '{1024, 2047, 8, 2, 33, 64, 0, 1, 0, 1024};
  int unsigned plan_root  [RANDOM_PHASES] = '{1, 1023, 100, 0, 32, 5, 7, 0, 0, 0};

  bitmap_entry_allocator dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .entry_index  (entry_index),
    .done         (done),
    .status       (status),
    .result_index (result_index),
    .is_used      (is_used),
    .free_total   (free_total),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data)
  );

  allocator_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .entry_index  (entry_index),
    .done         (done),
    .status       (status),
    .result_index (result_index),
    .is_used      (is_used),
    .free_total   (free_total),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .mismatches   (mismatches),
    .backlog      (backlog),
    .results_seen (results_seen),
    .grants       (grants),
    .exhausted    (exhausted)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done === 1'b1 || wr_en) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Holds start until the command is accepted; start stays high for a burst.
  task automatic issue(input logic [2:0] op, input logic [IDX_W-1:0] idx);
    int unsigned gap;
    start       <= 1'b1;
    operation   <= op;
    entry_index <= idx;
    do @(posedge clk); while (busy !== 1'b0);
    commands_issued++;
    if (idling) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 5);
        start <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(1, 16);
      end
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
  endtask

  task automatic program_regs(input int unsigned count, input int unsigned root);
    settle();
    wr_en    <= 1'b1;
    wr_index <= REG_ENTRY_COUNT;
    wr_data  <= CNT_W'(count);
    @(posedge clk);
    // top bit is outside the root register and must be dropped
    wr_index <= REG_ROOT_INDEX;
    wr_data  <= {1'($urandom_range(0, 1)), IDX_W'(root)};
    @(posedge clk);
    wr_en    <= 1'b0;
    cur_span = (count > MAX_ENTRIES) ? MAX_ENTRIES : count;
    settings_used++;
  endtask

  function automatic logic [IDX_W-1:0] pick_index();
    if (cur_span < 2 || $urandom_range(0, 4) == 0) return IDX_W'($urandom);
    return IDX_W'($urandom_range(1, cur_span - 1));
  endfunction

  task automatic random_command();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45)      issue(OP_ALLOC, IDX_W'($urandom));
    else if (pick < 70) issue(OP_FREE, pick_index());
    else if (pick < 80) issue(OP_QUERY, pick_index());
    else if (pick < 88) issue(OP_COUNT, IDX_W'($urandom));
    else if (pick < 92) issue(OP_INIT, IDX_W'($urandom));
    else if (pick < 95) issue(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), IDX_W'($urandom));
    else                issue(3'($urandom), IDX_W'($urandom));
  endtask

  initial begin
    int unsigned count;
    int unsigned root;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset map before any init, default registers
    issue(OP_QUERY, '0);
    issue(OP_COUNT, '0);
    issue(OP_ALLOC, '0);        // counter already at zero
    issue(OP_FREE, '0);
    issue(OP_FREE, '1);
    for (int op = OP_SPARE_LO; op <= OP_SPARE_HI; op++) issue(3'(op), '1);
    issue(OP_INIT, '0);
    issue(OP_QUERY, IDX_W'(1));
    issue(OP_QUERY, '0);
    issue(OP_ALLOC, '1);
    issue(OP_COUNT, '0);
    issue(OP_FREE, IDX_W'(2));
    issue(OP_FREE, IDX_W'(2));  // already free
    issue(OP_QUERY, '1);

    // smallest legal map
    program_regs(2, 1);
    issue(OP_INIT, '0);
    issue(OP_ALLOC, '0);
    issue(OP_FREE, IDX_W'(1));
    issue(OP_FREE, IDX_W'(2));
    issue(OP_QUERY, IDX_W'(5));
    issue(OP_ALLOC, '0);

    // empty map
    program_regs(0, 7);
    issue(OP_INIT, '0);
    issue(OP_ALLOC, '0);
    issue(OP_QUERY, '0);
    issue(OP_COUNT, '0);
    issue(OP_FREE, IDX_W'(1));

    // raise the counter with repeated frees, most of them on entries already free
    program_regs(MAX_ENTRIES, 1);
    idling     = 1'b1;
    burst_left = $urandom_range(1, 16);
    issue(OP_INIT, '0);
    repeat (SWEEP_FREES) issue(OP_FREE, IDX_W'($urandom_range(1, MAX_ENTRIES - 1)));
    issue(OP_COUNT, '0);
    issue(OP_ALLOC, '0);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      count = plan_count[phase];
      root  = plan_root[phase];
      if (phase == RANDOM_PHASES - 2) begin
        count = $urandom_range(2, MAX_ENTRIES);
        root  = $urandom_range(0, MAX_ENTRIES - 1);
      end
      program_regs(count, root);
      idling     = (phase % 4 != 1);
      burst_left = $urandom_range(1, 16);
      issue(OP_INIT, IDX_W'($urandom));
      repeat (PHASE_ITEMS) random_command();
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d commands over %0d register settings, %0d results compared",
             commands_issued, settings_used, results_seen);
    $display("allocations granted %0d, refused for a full map %0d", grants, exhausted);
    if (mismatches == 0 && backlog == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/bea_pkg.sv
sv/bea_ram.sv
sv/bitmap_entry_allocator.sv
dv/allocator_checker.sv
dv/tb_bitmap_entry_allocator.sv
